### rtl/core/lac_pkg.sv
// ----------------------------------------------------------------------------
// lac_pkg
// shared sizes, codes and transaction types of the lru age cache tag store
// ----------------------------------------------------------------------------
package lac_pkg;

    localparam int ENTRIES  = 16;
    localparam int KEY_BITS = 32;
    localparam int AGE_BITS = 16;
    localparam int IDX_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_STORE  = 1'b1;

    typedef logic [IDX_BITS-1:0] t_idx;
    typedef logic [KEY_BITS-1:0] t_key;
    typedef logic [AGE_BITS-1:0] t_age;

    // request and result transactions
    typedef struct packed {
        logic        cmd;
        logic [31:0] key;
    } t_req;

    typedef struct packed {
        logic       hit;
        logic [3:0] slot;
    } t_res;

    // one word of the entry memory
    typedef struct packed {
        t_key key;
        t_age age;
    } t_entry;

    // scan unit control and status
    typedef struct packed {
        logic clear;
        logic en;
        logic valid;
        t_idx idx;
        t_key key;
    } t_scan_ctl;

    typedef struct packed {
        logic hit;
        t_idx hit_idx;
        t_idx victim;
    } t_scan_res;

    // keep the low key bits, zero extended where the key is wider than the port
    function automatic t_key key_of(input logic [31:0] k);
        logic [63:0] w;
        w = {32'b0, k};
        return w[KEY_BITS-1:0];
    endfunction

    // entry index on the 4-bit slot field
    function automatic logic [3:0] slot_of(input t_idx i);
        logic [7:0] w;
        w = 8'(i);
        return w[3:0];
    endfunction

    function automatic t_age age_inc(input t_age a);
        return (a == {AGE_BITS{1'b1}}) ? a : a + t_age'(1);
    endfunction

endpackage

### rtl/core/lac_entry_ram.sv
// ----------------------------------------------------------------------------
// lac_entry_ram
// key and age memory, one write and one read port, registered read data
// ----------------------------------------------------------------------------
module lac_entry_ram
    import lac_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_we,
    input  t_idx   i_waddr,
    input  t_entry i_wdata,
    input  logic   i_re,
    input  t_idx   i_raddr,
    output t_entry o_rdata
);

    t_entry r_mem [ENTRIES];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/lac_scan.sv
// ----------------------------------------------------------------------------
// lac_scan
// walks the entries one per cycle while enabled: first valid key match and victim choice
// ----------------------------------------------------------------------------
module lac_scan
    import lac_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_scan_ctl i_ctl,
    input  t_entry    i_entry,
    output t_scan_res o_res
);

    logic r_found;
    t_idx r_hit_idx;
    logic r_empty;
    t_idx r_victim;
    t_age r_best;

    logic n_found;
    t_idx n_hit_idx;
    logic n_empty;
    t_idx n_victim;
    t_age n_best;

    always_comb begin
        n_found   = r_found;
        n_hit_idx = r_hit_idx;
        n_empty   = r_empty;
        n_victim  = r_victim;
        n_best    = r_best;
        if (i_ctl.clear) begin
            n_found   = 1'b0;
            n_hit_idx = '0;
            n_empty   = 1'b0;
            n_victim  = '0;
            n_best    = '0;
        end else if (i_ctl.en) begin
            if (i_ctl.valid && !r_found && (i_entry.key == i_ctl.key)) begin
                n_found   = 1'b1;
                n_hit_idx = i_ctl.idx;
            end
            // first empty entry wins, else strictly oldest
            if (!r_empty) begin
                if (!i_ctl.valid) begin
                    n_empty  = 1'b1;
                    n_victim = i_ctl.idx;
                end else if (i_entry.age > r_best) begin
                    n_best   = i_entry.age;
                    n_victim = i_ctl.idx;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
            r_empty <= 1'b0;
        end else begin
            r_found <= n_found;
            r_empty <= n_empty;
        end
        r_hit_idx <= n_hit_idx;
        r_victim  <= n_victim;
        r_best    <= n_best;
    end

    assign o_res.hit     = r_found;
    assign o_res.hit_idx = r_hit_idx;
    assign o_res.victim  = r_victim;

endmodule

### rtl/core/lru_age_object_cache_tags_top.sv
// ----------------------------------------------------------------------------
// lru_age_object_cache_tags_top
// tag store of a fully associative cache with saturating lru age counters
// ----------------------------------------------------------------------------
// a lookup miss makes one read pass over the entry memory for the search; a
//   hit or store adds one read-modify-write aging pass over the entry memory
// throughput: busy drops in the strobe cycle, so a new transaction may follow
//   at once; the receiver cannot stall, results are never held
// reset: synchronous active low, clears all valid flags (cache empty), no sweep
// ----------------------------------------------------------------------------
module lru_age_object_cache_tags_top
    import lac_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_req i_req,
    output logic busy,
    output logic o_valid,
    output t_res o_res
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_AGE
    } t_state;

    // sequencer state
    t_state               r_state,  n_state;
    logic                 r_cmd,    n_cmd;
    t_key                 r_key,    n_key;
    logic [IDX_BITS:0]    r_cnt,    n_cnt;     // read address, counts to ENTRIES
    logic                 r_rd_vld, n_rd_vld;  // read data present this cycle
    t_idx                 r_rd_idx, n_rd_idx;  // entry the read data belongs to
    t_idx                 r_keep,   n_keep;    // entry that is not aged
    logic [ENTRIES-1:0]   r_valid,  n_valid;
    logic                 r_out_vld, n_out_vld;
    t_res                 r_out,    n_out;

    // memory and scan hookup
    logic      re;
    t_idx      raddr;
    logic      we;
    t_entry    wdata;
    t_entry    rdata;
    t_scan_ctl scan_ctl;
    t_scan_res scan_res;
    logic      issue;
    logic      last;

    localparam t_idx LAST_IDX = t_idx'(ENTRIES - 1);

    lac_entry_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_rd_idx),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    lac_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (scan_ctl),
        .i_entry (rdata),
        .o_res   (scan_res)
    );

    // one read issued per cycle during either pass
    assign issue = ((r_state == S_SCAN) || (r_state == S_AGE))
                   && (r_cnt < (IDX_BITS+1)'(ENTRIES));
    assign re    = issue;
    assign raddr = r_cnt[IDX_BITS-1:0];
    assign last  = r_rd_vld && (r_rd_idx == LAST_IDX);

    // search pass feeds the scan unit
    always_comb begin
        scan_ctl.clear = (r_state == S_IDLE);
        scan_ctl.en    = (r_state == S_SCAN) && r_rd_vld;
        scan_ctl.valid = r_valid[r_rd_idx];
        scan_ctl.idx   = r_rd_idx;
        scan_ctl.key   = r_key;
    end

    // aging pass writes back each valid entry just read with its age bumped; the kept
    // entry gets the new key and age zero on a store and is left alone on a lookup hit
    always_comb begin
        we    = 1'b0;
        wdata = rdata;
        if ((r_state == S_AGE) && r_rd_vld) begin
            if (r_rd_idx == r_keep) begin
                we        = (r_cmd == CMD_STORE);
                wdata.key = r_key;
                wdata.age = '0;
            end else begin
                we        = r_valid[r_rd_idx];
                wdata.key = rdata.key;
                wdata.age = age_inc(rdata.age);
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_key     = r_key;
        n_cnt     = r_cnt;
        n_rd_vld  = issue;
        n_rd_idx  = issue ? raddr : r_rd_idx;
        n_keep    = r_keep;
        n_valid   = r_valid;
        n_out_vld = 1'b0;
        n_out     = r_out;
        if (issue) begin
            n_cnt = r_cnt + (IDX_BITS+1)'(1);
        end
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cmd   = i_req.cmd;
                    n_key   = key_of(i_req.key);
                    n_cnt   = '0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (last) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if ((r_cmd == CMD_LOOKUP) && !scan_res.hit) begin
                    // miss leaves every entry untouched
                    n_out_vld = 1'b1;
                    n_out.hit  = 1'b0;
                    n_out.slot = '0;
                    n_state    = S_IDLE;
                end else begin
                    n_keep  = (r_cmd == CMD_STORE) ? scan_res.victim : scan_res.hit_idx;
                    n_cnt   = '0;
                    n_state = S_AGE;
                    if (r_cmd == CMD_STORE) begin
                        n_valid[scan_res.victim] = 1'b1;
                    end
                end
            end
            S_AGE: begin
                if (last) begin
                    n_out_vld  = 1'b1;
                    n_out.hit  = (r_cmd == CMD_LOOKUP);
                    n_out.slot = slot_of(r_keep);
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_rd_vld  <= 1'b0;
            r_valid   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_rd_vld  <= n_rd_vld;
            r_valid   <= n_valid;
            r_out_vld <= n_out_vld;
        end
        r_cmd    <= n_cmd;
        r_key    <= n_key;
        r_rd_idx <= n_rd_idx;
        r_keep   <= n_keep;
        r_out    <= n_out;
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_out_vld;
    assign o_res   = r_out;

    // a result only appears once the sequencer is back to idle
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    // an accepted transaction keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not start");

    // hit is reported for lookups only
    a_hit_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.hit) |-> (r_cmd == CMD_LOOKUP))
        else $error("hit reported for a store");

    // memory writes belong to the aging pass only
    a_write_age: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |-> ((r_state == S_AGE) && r_rd_vld))
        else $error("entry write outside aging pass");

    // a store leaves its victim valid
    a_store_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (r_cmd == CMD_STORE)) |-> r_valid[r_keep])
        else $error("stored entry not valid");

endmodule
